>>> hdl/ssa_pkg.sv
`timescale 1ns / 1ps
package ssa_pkg;

  // request codes
  localparam logic [1:0] REQ_QUERY   = 2'd0;
  localparam logic [1:0] REQ_KV      = 2'd1;
  localparam logic [1:0] REQ_SINK    = 2'd2;
  localparam logic [1:0] REQ_COMPUTE = 2'd3;

  // status codes
  localparam logic [1:0] STAT_OK  = 2'd0;
  localparam logic [1:0] STAT_IDX = 2'd1;
  localparam logic [1:0] STAT_SAT = 2'd2;

  // configuration register indexes
  localparam logic [1:0] CFG_HEAD_COUNT  = 2'd0;
  localparam logic [1:0] CFG_TOKEN_COUNT = 2'd1;
  localparam logic [1:0] CFG_HEAD_DIM    = 2'd2;
  localparam logic [1:0] CFG_SCORE_SCALE = 2'd3;

  // one classified request in the queue
  typedef struct packed {
    logic [1:0]        req;
    logic [3:0]        head;
    logic [7:0]        tok;
    logic [6:0]        dim;
    logic signed [15:0] val;
    logic              bad;
  } item_t;

  // exp(-k/16) in Q1.15, k = 0..16
  function automatic logic [15:0] exp_frac(input logic [4:0] k);
    logic [15:0] r;
    case (k)
      5'd0:    r = 16'd32768;
      5'd1:    r = 16'd30783;
      5'd2:    r = 16'd28918;
      5'd3:    r = 16'd27166;
      5'd4:    r = 16'd25520;
      5'd5:    r = 16'd23974;
      5'd6:    r = 16'd22521;
      5'd7:    r = 16'd21157;
      5'd8:    r = 16'd19875;
      5'd9:    r = 16'd18671;
      5'd10:   r = 16'd17540;
      5'd11:   r = 16'd16477;
      5'd12:   r = 16'd15479;
      5'd13:   r = 16'd14541;
      5'd14:   r = 16'd13660;
      5'd15:   r = 16'd12832;
      5'd16:   r = 16'd12055;
      default: r = 16'd0;
    endcase
    return r;
  endfunction

  // exp(-i) in Q1.15, i = 0..11
  function automatic logic [15:0] exp_int(input logic [3:0] i);
    logic [15:0] r;
    case (i)
      4'd0:    r = 16'd32768;
      4'd1:    r = 16'd12055;
      4'd2:    r = 16'd4435;
      4'd3:    r = 16'd1631;
      4'd4:    r = 16'd600;
      4'd5:    r = 16'd221;
      4'd6:    r = 16'd81;
      4'd7:    r = 16'd30;
      4'd8:    r = 16'd11;
      4'd9:    r = 16'd4;
      4'd10:   r = 16'd1;
      4'd11:   r = 16'd1;
      default: r = 16'd0;
    endcase
    return r;
  endfunction

endpackage

>>> hdl/ssa_ram.sv
`timescale 1ns / 1ps
module ssa_ram #(
  parameter int W     = 16,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic [W-1:0]  wdata_i,
  input  logic [AW-1:0] raddr_i,
  output logic [W-1:0]  rdata_o
);

  logic [W-1:0] mem [DEPTH];

  // write one entry, register the read
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

>>> hdl/ssa_front.sv
`timescale 1ns / 1ps
module ssa_front import ssa_pkg::*; #(
  parameter int HCW = 5,
  parameter int TCW = 9,
  parameter int DCW = 8
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  output logic               busy_o,
  input  logic [1:0]         req_type_i,
  input  logic [3:0]         head_index_i,
  input  logic [7:0]         token_index_i,
  input  logic [6:0]         dim_index_i,
  input  logic signed [15:0] element_value_i,
  input  logic [HCW-1:0]     nh_i,
  input  logic [TCW-1:0]     nt_i,
  input  logic [DCW-1:0]     nd_i,
  input  logic               pop_i,
  output logic               valid_o,
  output item_t              item_o
);

  item_t      ent_q [2];
  logic       wr_q, wr_d, rd_q, rd_d;
  logic [1:0] cnt_q, cnt_d;
  logic       push, h_ok, t_ok, d_ok;
  item_t      cls;

  assign busy_o  = (cnt_q == 2'd2);
  assign valid_o = (cnt_q != 2'd0);
  assign push    = start_i && !busy_o;
  assign item_o  = ent_q[rd_q];

  // classify against the configured sizes
  assign h_ok = 32'(head_index_i) < 32'(nh_i);
  assign t_ok = 32'(token_index_i) < 32'(nt_i);
  assign d_ok = 32'(dim_index_i) < 32'(nd_i);

  always_comb begin
    cls.req  = req_type_i;
    cls.head = head_index_i;
    cls.tok  = token_index_i;
    cls.dim  = dim_index_i;
    cls.val  = element_value_i;
    case (req_type_i)
      REQ_QUERY: cls.bad = !(h_ok && d_ok);
      REQ_KV:    cls.bad = !(t_ok && d_ok);
      REQ_SINK:  cls.bad = !h_ok;
      default:   cls.bad = !(h_ok && d_ok);
    endcase
  end

  // advance queue pointers
  always_comb begin
    wr_d  = push ? !wr_q : wr_q;
    rd_d  = (pop_i && valid_o) ? !rd_q : rd_q;
    cnt_d = cnt_q + 2'(push) - 2'(pop_i && valid_o);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  // hold queued items
  always_ff @(posedge clk_i) begin
    if (push) begin
      ent_q[wr_q] <= cls;
    end
  end

endmodule

>>> hdl/ssa_div.sv
`timescale 1ns / 1ps
module ssa_div #(
  parameter int NW = 43,
  parameter int DW = 26
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  logic [NW-1:0] dividend_i,
  input  logic [DW-1:0] divisor_i,
  output logic          done_o,
  output logic [NW-1:0] quot_o
);

  localparam int CNW = $clog2(NW + 1);

  logic [NW-1:0]  quo_q, quo_d;
  logic [DW-1:0]  rem_q, rem_d, dvs_q;
  logic [CNW-1:0] cnt_q, cnt_d;
  logic           run_q, run_d, done_q, done_d;
  logic [DW:0]    sh;
  logic           bit_ok;

  assign sh     = {rem_q, quo_q[NW-1]};
  assign bit_ok = sh >= {1'b0, dvs_q};
  assign done_o = done_q;
  assign quot_o = quo_q;

  // one quotient bit per cycle, restoring
  always_comb begin
    quo_d  = quo_q;
    rem_d  = rem_q;
    cnt_d  = cnt_q;
    run_d  = run_q;
    done_d = 1'b0;
    if (start_i) begin
      quo_d = dividend_i;
      rem_d = '0;
      cnt_d = CNW'(NW);
      run_d = 1'b1;
    end else if (run_q) begin
      quo_d = {quo_q[NW-2:0], bit_ok};
      rem_d = bit_ok ? DW'(sh - {1'b0, dvs_q}) : DW'(sh);
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CNW'(1)) begin
        run_d  = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      run_q  <= run_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    if (start_i) begin
      dvs_q <= divisor_i;
    end
  end

endmodule

>>> hdl/ssa_back.sv
`timescale 1ns / 1ps
module ssa_back import ssa_pkg::*; #(
  parameter int MAX_HEADS    = 16,
  parameter int MAX_TOKENS   = 256,
  parameter int MAX_HEAD_DIM = 128,
  parameter int TCW          = 9,
  parameter int DCW          = 8
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               valid_i,
  input  item_t              item_i,
  output logic               pop_o,
  input  logic [TCW-1:0]     nt_i,
  input  logic [DCW-1:0]     nd_i,
  input  logic [15:0]        scale_i,
  output logic               done_o,
  output logic signed [15:0] result_value_o,
  output logic [1:0]         result_status_o
);

  localparam int QD   = MAX_HEADS * MAX_HEAD_DIM;
  localparam int KD   = MAX_TOKENS * MAX_HEAD_DIM;
  localparam int QAW  = (QD > 1) ? $clog2(QD) : 1;
  localparam int KAW  = (KD > 1) ? $clog2(KD) : 1;
  localparam int SAW  = (MAX_TOKENS > 1) ? $clog2(MAX_TOKENS) : 1;
  localparam int HAW  = (MAX_HEADS > 1) ? $clog2(MAX_HEADS) : 1;
  localparam int ACCW = 33 + $clog2(MAX_HEAD_DIM + 1);
  localparam int SCW  = ACCW + 17;
  localparam int SW   = SCW - 22;
  localparam int NUMW = 34 + $clog2(MAX_TOKENS + 1);
  localparam int DENW = 17 + $clog2(MAX_TOKENS + 2);
  localparam int NW   = NUMW + 2;
  localparam int DVW  = DENW + 1;

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_DOT    = 4'd1;
  localparam logic [3:0] S_DRAIN  = 4'd2;
  localparam logic [3:0] S_SCALE  = 4'd3;
  localparam logic [3:0] S_SCORE  = 4'd4;
  localparam logic [3:0] S_EXPS   = 4'd5;
  localparam logic [3:0] S_EXPT   = 4'd6;
  localparam logic [3:0] S_EDRAIN = 4'd7;
  localparam logic [3:0] S_DIVGO  = 4'd8;
  localparam logic [3:0] S_DIV    = 4'd9;

  localparam logic signed [SCW-1:0] RND = SCW'(2097152);

  logic [3:0]     st_q, st_d;
  logic [DCW-1:0] e_q, e_d;
  logic [TCW-1:0] t_q, t_d;
  logic [3:0]     cur_head_q;
  logic [6:0]     cur_dim_q;

  // memory ports
  logic           q_we, k_we, s_we, sc_we;
  logic [QAW-1:0] q_waddr, q_raddr;
  logic [KAW-1:0] k_waddr, k_raddr;
  logic [HAW-1:0] s_waddr, s_raddr;
  logic [SAW-1:0] sc_addr;
  logic [15:0]    q_rdata, k_rdata, s_rdata;
  logic [SW-1:0]  sc_wdata, sc_rdata;

  // dot product pipe
  logic                   iss_v, iss_l;
  logic                   rv_q, rl_q, pv_q, pl_q;
  logic signed [31:0]     prod_q;
  logic signed [ACCW-1:0] acc_q, acc_d;
  logic signed [SCW-1:0]  sc_q;
  logic signed [SW-1:0]   score, sink_s, base, max_q, max_d;

  // weight pipe
  logic                   eiss_v, eiss_s, eiss_l;
  logic                   av_q, as_q, al_q, bv_q, bl_q, cv_q, cl_q;
  logic signed [SW-1:0]   src;
  logic [SW:0]            diff;
  logic [4:0]             fk;
  logic [5:0]             flo;
  logic [15:0]            fa, fb, e_val, e_q2;
  logic [21:0]            interp;
  logic                   ez, ez_q;
  logic [3:0]             ip_q;
  logic signed [15:0]     kva, kvb_q, kvc_q;
  logic [31:0]            wfull;
  logic [15:0]            w_q;
  logic signed [32:0]     prodw;
  logic signed [NUMW-1:0] num_q, num_d;
  logic [DENW-1:0]        den_q, den_d;
  logic                   clr_acc;

  // divide and result
  logic            neg;
  logic [NUMW-1:0] mag;
  logic            div_go, div_done;
  logic [NW-1:0]   quo;
  logic            done_q, done_d;
  logic [15:0]     val_q, val_d;
  logic [1:0]      stat_q, stat_d;

  ssa_ram #(.W(16), .DEPTH(QD), .AW(QAW)) u_qram (
    .clk_i(clk_i), .we_i(q_we), .waddr_i(q_waddr), .wdata_i(item_i.val),
    .raddr_i(q_raddr), .rdata_o(q_rdata)
  );
  ssa_ram #(.W(16), .DEPTH(KD), .AW(KAW)) u_kram (
    .clk_i(clk_i), .we_i(k_we), .waddr_i(k_waddr), .wdata_i(item_i.val),
    .raddr_i(k_raddr), .rdata_o(k_rdata)
  );
  ssa_ram #(.W(16), .DEPTH(MAX_HEADS), .AW(HAW)) u_sram (
    .clk_i(clk_i), .we_i(s_we), .waddr_i(s_waddr), .wdata_i(item_i.val),
    .raddr_i(s_raddr), .rdata_o(s_rdata)
  );
  ssa_ram #(.W(SW), .DEPTH(MAX_TOKENS), .AW(SAW)) u_scram (
    .clk_i(clk_i), .we_i(sc_we), .waddr_i(sc_addr), .wdata_i(sc_wdata),
    .raddr_i(sc_addr), .rdata_o(sc_rdata)
  );

  ssa_div #(.NW(NW), .DW(DVW)) u_div (
    .clk_i(clk_i), .rst_ni(rst_ni), .start_i(div_go),
    .dividend_i(NW'({mag, 1'b0}) + NW'(den_q)),
    .divisor_i({den_q, 1'b0}),
    .done_o(div_done), .quot_o(quo)
  );

  // load write addresses
  assign q_waddr = QAW'(32'(item_i.head) * MAX_HEAD_DIM + 32'(item_i.dim));
  assign k_waddr = KAW'(32'(item_i.tok) * MAX_HEAD_DIM + 32'(item_i.dim));
  assign s_waddr = HAW'(item_i.head);

  // compute read addresses
  assign q_raddr = QAW'(32'(cur_head_q) * MAX_HEAD_DIM + 32'(e_q));
  assign k_raddr = (st_q == S_DOT) ? KAW'(32'(t_q) * MAX_HEAD_DIM + 32'(e_q))
                                   : KAW'(32'(t_q) * MAX_HEAD_DIM + 32'(cur_dim_q));
  assign s_raddr = HAW'(cur_head_q);
  assign sc_addr = SAW'(t_q);

  // score and running maximum
  assign score  = SW'((sc_q + RND) >>> 22);
  assign sink_s = SW'($signed(s_rdata));
  assign base   = (t_q == '0) ? sink_s : max_q;
  assign max_d  = (score > base) ? score : base;
  assign sc_wdata = score;

  // exponential of the non-positive difference
  assign src   = as_q ? sink_s : $signed(sc_rdata);
  assign diff  = (SW + 1)'(max_q) - (SW + 1)'(src);
  assign ez    = diff[SW:10] >= (SW - 9)'(12);
  assign fk    = {1'b0, diff[9:6]};
  assign flo   = diff[5:0];
  assign fa    = exp_frac(fk);
  assign fb    = exp_frac(fk + 5'd1);
  assign interp = 22'(fa - fb) * 22'(flo) + 22'd32;
  assign e_val = fa - 16'(interp >> 6);
  assign kva   = as_q ? 16'sd0 : $signed(k_rdata);
  assign wfull = 32'(exp_int(ip_q)) * 32'(e_q2) + 32'd16384;
  assign prodw = $signed({1'b0, w_q}) * kvc_q;

  // sign and magnitude of the numerator
  assign neg = num_q < 0;
  assign mag = neg ? NUMW'(-num_q) : NUMW'(num_q);

  assign done_o          = done_q;
  assign result_value_o  = $signed(val_q);
  assign result_status_o = stat_q;

  // sequencer
  always_comb begin
    st_d    = st_q;
    e_d     = e_q;
    t_d     = t_q;
    pop_o   = 1'b0;
    q_we    = 1'b0;
    k_we    = 1'b0;
    s_we    = 1'b0;
    sc_we   = 1'b0;
    iss_v   = 1'b0;
    iss_l   = 1'b0;
    eiss_v  = 1'b0;
    eiss_s  = 1'b0;
    eiss_l  = 1'b0;
    clr_acc = 1'b0;
    div_go  = 1'b0;
    done_d  = 1'b0;
    val_d   = val_q;
    stat_d  = stat_q;
    case (st_q)
      S_IDLE: begin
        if (valid_i) begin
          pop_o  = 1'b1;
          val_d  = 16'd0;
          stat_d = STAT_OK;
          if (item_i.bad) begin
            done_d = 1'b1;
            stat_d = STAT_IDX;
          end else begin
            case (item_i.req)
              REQ_QUERY: begin
                q_we   = 1'b1;
                done_d = 1'b1;
              end
              REQ_KV: begin
                k_we   = 1'b1;
                done_d = 1'b1;
              end
              REQ_SINK: begin
                s_we   = 1'b1;
                done_d = 1'b1;
              end
              default: begin
                e_d     = '0;
                t_d     = '0;
                clr_acc = 1'b1;
                st_d    = S_DOT;
              end
            endcase
          end
        end
      end
      S_DOT: begin
        iss_v = 1'b1;
        iss_l = (e_q == nd_i - 1'b1);
        e_d   = e_q + 1'b1;
        if (iss_l) begin
          st_d = S_DRAIN;
        end
      end
      S_DRAIN: begin
        if (pv_q && pl_q) begin
          st_d = S_SCALE;
        end
      end
      S_SCALE: begin
        st_d = S_SCORE;
      end
      S_SCORE: begin
        sc_we   = 1'b1;
        clr_acc = 1'b1;
        e_d     = '0;
        if (t_q == nt_i - 1'b1) begin
          t_d  = '0;
          st_d = S_EXPS;
        end else begin
          t_d  = t_q + 1'b1;
          st_d = S_DOT;
        end
      end
      S_EXPS: begin
        eiss_v = 1'b1;
        eiss_s = 1'b1;
        st_d   = S_EXPT;
      end
      S_EXPT: begin
        eiss_v = 1'b1;
        eiss_l = (t_q == nt_i - 1'b1);
        t_d    = t_q + 1'b1;
        if (eiss_l) begin
          st_d = S_EDRAIN;
        end
      end
      S_EDRAIN: begin
        if (cv_q && cl_q) begin
          st_d = S_DIVGO;
        end
      end
      S_DIVGO: begin
        div_go = 1'b1;
        st_d   = S_DIV;
      end
      S_DIV: begin
        if (div_done) begin
          done_d = 1'b1;
          st_d   = S_IDLE;
          if (neg) begin
            if (quo > NW'(32768)) begin
              val_d  = 16'h8000;
              stat_d = STAT_SAT;
            end else begin
              val_d  = -quo[15:0];
              stat_d = STAT_OK;
            end
          end else begin
            if (quo > NW'(32767)) begin
              val_d  = 16'h7FFF;
              stat_d = STAT_SAT;
            end else begin
              val_d  = quo[15:0];
              stat_d = STAT_OK;
            end
          end
        end
      end
      default: st_d = S_IDLE;
    endcase
  end

  // accumulate dot product and weights
  always_comb begin
    acc_d = acc_q;
    if (clr_acc) begin
      acc_d = '0;
    end else if (pv_q) begin
      acc_d = acc_q + ACCW'(prod_q);
    end
    num_d = num_q;
    den_d = den_q;
    if (st_q == S_EXPS) begin
      num_d = '0;
      den_d = '0;
    end else if (cv_q) begin
      num_d = num_q + NUMW'(prodw);
      den_d = den_q + DENW'(w_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q   <= S_IDLE;
      rv_q   <= 1'b0;
      rl_q   <= 1'b0;
      pv_q   <= 1'b0;
      pl_q   <= 1'b0;
      av_q   <= 1'b0;
      as_q   <= 1'b0;
      al_q   <= 1'b0;
      bv_q   <= 1'b0;
      bl_q   <= 1'b0;
      cv_q   <= 1'b0;
      cl_q   <= 1'b0;
      done_q <= 1'b0;
      e_q    <= '0;
      t_q    <= '0;
    end else begin
      st_q   <= st_d;
      rv_q   <= iss_v;
      rl_q   <= iss_l;
      pv_q   <= rv_q;
      pl_q   <= rv_q && rl_q;
      av_q   <= eiss_v;
      as_q   <= eiss_s;
      al_q   <= eiss_l;
      bv_q   <= av_q;
      bl_q   <= av_q && al_q;
      cv_q   <= bv_q;
      cl_q   <= bv_q && bl_q;
      done_q <= done_d;
      e_q    <= e_d;
      t_q    <= t_d;
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    if (st_q == S_IDLE && valid_i) begin
      cur_head_q <= item_i.head;
      cur_dim_q  <= item_i.dim;
    end
    prod_q <= $signed(q_rdata) * $signed(k_rdata);
    acc_q  <= acc_d;
    sc_q   <= SCW'(acc_q) * SCW'($signed({1'b0, scale_i}));
    if (st_q == S_SCORE) begin
      max_q <= max_d;
    end
    e_q2   <= e_val;
    ez_q   <= ez;
    ip_q   <= diff[13:10];
    kvb_q  <= kva;
    w_q    <= ez_q ? 16'd0 : wfull[30:15];
    kvc_q  <= kvb_q;
    num_q  <= num_d;
    den_q  <= den_d;
    val_q  <= val_d;
    stat_q <= stat_d;
  end

endmodule

>>> hdl/sink_softmax_attention.sv
`timescale 1ns / 1ps
// Sink-logit softmax attention over shared key/value tokens, Q6.10 data.
// Issue an item with start_i while busy_o is low; every item gives exactly
// one result, shown for one cycle with done_o, and the receiver cannot stall
// it. Loads and rejected requests pass through the two-entry queue and
// the back-end. In a compute request the score pass reads one query and
// one key element per cycle from the single-read-port memories, the
// weight pass one token per cycle, and a bit-serial divider forms the
// quotient. Write the configuration only while the block is idle.
module sink_softmax_attention import ssa_pkg::*; #(
  parameter int MAX_HEADS    = 16,
  parameter int MAX_TOKENS   = 256,
  parameter int MAX_HEAD_DIM = 128
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  output logic               busy_o,
  input  logic [1:0]         req_type_i,
  input  logic [3:0]         head_index_i,
  input  logic [7:0]         token_index_i,
  input  logic [6:0]         dim_index_i,
  input  logic signed [15:0] element_value_i,
  input  logic               cfg_we_i,
  input  logic [1:0]         cfg_idx_i,
  input  logic [15:0]        cfg_wdata_i,
  output logic               done_o,
  output logic signed [15:0] result_value_o,
  output logic [1:0]         result_status_o
);

  localparam int HCW = $clog2(MAX_HEADS + 1);
  localparam int TCW = $clog2(MAX_TOKENS + 1);
  localparam int DCW = $clog2(MAX_HEAD_DIM + 1);

  logic [4:0]     head_count_q;
  logic [8:0]     token_count_q;
  logic [7:0]     head_dim_q;
  logic [15:0]    score_scale_q;
  logic [HCW-1:0] nh;
  logic [TCW-1:0] nt;
  logic [DCW-1:0] nd;
  logic           q_valid, q_pop;
  item_t          q_item;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_count_q  <= 5'd1;
      token_count_q <= 9'd1;
      head_dim_q    <= 8'd1;
      score_scale_q <= 16'd4096;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_HEAD_COUNT:  head_count_q  <= cfg_wdata_i[4:0];
        CFG_TOKEN_COUNT: token_count_q <= cfg_wdata_i[8:0];
        CFG_HEAD_DIM:    head_dim_q    <= cfg_wdata_i[7:0];
        default:         score_scale_q <= cfg_wdata_i;
      endcase
    end
  end

  // clamp sizes into [1, max]
  always_comb begin
    if (head_count_q == '0) nh = HCW'(1);
    else if (32'(head_count_q) > MAX_HEADS) nh = HCW'(MAX_HEADS);
    else nh = HCW'(head_count_q);
    if (token_count_q == '0) nt = TCW'(1);
    else if (32'(token_count_q) > MAX_TOKENS) nt = TCW'(MAX_TOKENS);
    else nt = TCW'(token_count_q);
    if (head_dim_q == '0) nd = DCW'(1);
    else if (32'(head_dim_q) > MAX_HEAD_DIM) nd = DCW'(MAX_HEAD_DIM);
    else nd = DCW'(head_dim_q);
  end

  ssa_front #(.HCW(HCW), .TCW(TCW), .DCW(DCW)) u_front (
    .clk_i(clk_i), .rst_ni(rst_ni), .start_i(start_i), .busy_o(busy_o),
    .req_type_i(req_type_i), .head_index_i(head_index_i),
    .token_index_i(token_index_i), .dim_index_i(dim_index_i),
    .element_value_i(element_value_i), .nh_i(nh), .nt_i(nt), .nd_i(nd),
    .pop_i(q_pop), .valid_o(q_valid), .item_o(q_item)
  );

  ssa_back #(
    .MAX_HEADS(MAX_HEADS), .MAX_TOKENS(MAX_TOKENS), .MAX_HEAD_DIM(MAX_HEAD_DIM),
    .TCW(TCW), .DCW(DCW)
  ) u_back (
    .clk_i(clk_i), .rst_ni(rst_ni), .valid_i(q_valid), .item_i(q_item),
    .pop_o(q_pop), .nt_i(nt), .nd_i(nd), .scale_i(score_scale_q),
    .done_o(done_o), .result_value_o(result_value_o),
    .result_status_o(result_status_o)
  );

`ifndef SYNTHESIS
  a_pop_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop |-> q_valid) else $error("queue popped while empty");
  a_push_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i && !busy_o |=> q_valid || $past(q_valid)) else $error("item lost");
  a_idx_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && result_status_o == STAT_IDX |-> result_value_o == 16'sd0)
    else $error("rejected item with nonzero value");
  a_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> result_status_o != 2'd3) else $error("bad status code");
`endif

endmodule
